// File: sv/smacc_pkg.sv
package smacc_pkg;

   // Default geometry of the accumulator store.
   localparam int DEF_SEGMENTS = 64;
   localparam int DEF_DIM      = 64;

   // Field widths of the words on the ports.
   localparam int OP_W  = 2;
   localparam int IDX_W = 6;
   localparam int VAL_W = 32;
   localparam int WOC_W = 16;

   // Q32.16 accumulator plus one sticky clip bit in each memory entry.
   localparam int ACC_W   = 48;
   localparam int ENTRY_W = ACC_W + 1;

   // The restoring divider retires one quotient bit per step.
   localparam int DIV_STEPS = ACC_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Quotient magnitude limits for a Q16.16 result.
   localparam logic [ACC_W-1:0] Q_POS_LIMIT = ACC_W'(64'h0000_7FFF_FFFF);
   localparam logic [ACC_W-1:0] Q_NEG_LIMIT = ACC_W'(64'h0000_8000_0000);
   localparam logic [VAL_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] Q_MIN       = 32'h8000_0000;

   // Configuration port: register index is paddr divided by four.
   localparam int   CSR_AW                 = 3;
   localparam logic CSR_IDX_EMPTY_DEFAULT  = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_WADD  = 2'd1,
      OP_FINAL = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic rd_en;
      logic calc;
      logic acc_write;
      logic div_load;
      logic div_step;
      logic fin;
      logic clr_write;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type opcode;
      logic       clr_last;
   } status_type;

endpackage

// File: sv/smacc_ram.sv
module smacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/smacc_ctrl.sv
module smacc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  smacc_pkg::status_type  status,
   output smacc_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CALC,
      S_ADD,
      S_DIV,
      S_FIN
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   logic [smacc_pkg::STEP_W-1:0]   step_ff;
   logic                           rsp_valid_ff;
   logic                           out_free;

   // The output register is free when empty or when its word leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CALC;
         end
         S_CALC: begin
            case (status.opcode)
               smacc_pkg::OP_ADD, smacc_pkg::OP_WADD: begin
                  cmd.calc = 1'b1;
                  state_in = S_ADD;
               end
               smacc_pkg::OP_FINAL: begin
                  cmd.div_load = 1'b1;
                  state_in     = S_DIV;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_ADD: begin
            cmd.acc_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == smacc_pkg::STEP_W'(smacc_pkg::DIV_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, divider step count and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.div_load) begin
            step_ff <= '0;
         end else if (cmd.div_step) begin
            step_ff <= step_ff + 1'b1;
         end
         if (cmd.fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/smacc_dpath.sv
module smacc_dpath #(
   parameter int SEGMENTS = smacc_pkg::DEF_SEGMENTS,
   parameter int DIM      = smacc_pkg::DEF_DIM
) (
   input  logic                           clock,
   input  logic                           reset,
   input  smacc_pkg::cmd_type             cmd,
   output smacc_pkg::status_type          status,
   input  logic [smacc_pkg::OP_W-1:0]     req_opcode,
   input  logic [smacc_pkg::IDX_W-1:0]    req_segment_index,
   input  logic [smacc_pkg::IDX_W-1:0]    req_element_index,
   input  logic signed [smacc_pkg::VAL_W-1:0] req_sample_value,
   input  logic [smacc_pkg::WOC_W-1:0]    req_weight_or_count,
   input  logic                           cfg_write,
   input  logic [smacc_pkg::VAL_W-1:0]    cfg_data,
   output logic [smacc_pkg::VAL_W-1:0]    empty_default,
   output logic signed [smacc_pkg::VAL_W-1:0] rsp_mean_value,
   output logic [smacc_pkg::IDX_W-1:0]    rsp_out_segment,
   output logic [smacc_pkg::IDX_W-1:0]    rsp_out_element,
   output logic                           rsp_was_empty,
   output logic                           rsp_saturated
);

   localparam int DEPTH = SEGMENTS * DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AW_W  = smacc_pkg::ACC_W;
   localparam int VW    = smacc_pkg::VAL_W;

   // Item registers.
   smacc_pkg::opcode_type              opcode_ff;
   logic [smacc_pkg::IDX_W-1:0]        seg_ff;
   logic [smacc_pkg::IDX_W-1:0]        elem_ff;
   logic signed [VW-1:0]               sample_ff;
   logic [smacc_pkg::WOC_W-1:0]        woc_ff;
   logic [AW-1:0]                      addr_ff;
   logic                               in_range_ff;
   logic                               in_range_in;
   logic [AW-1:0]                      addr_in;

   // Configuration and clearing pass.
   logic [VW-1:0]                      empty_default_ff;
   logic [AW-1:0]                      clr_addr_ff;

   // Accumulate and divide registers.
   logic [AW_W-1:0]                    addend_ff;
   logic [AW_W-1:0]                    quo_ff;
   logic [smacc_pkg::WOC_W-1:0]        rem_ff;
   logic                               neg_ff;
   logic                               clip_ff;

   // Memory ports.
   logic                               ram_wr_en;
   logic [AW-1:0]                      ram_wr_addr;
   logic [smacc_pkg::ENTRY_W-1:0]      ram_wr_data;
   logic [smacc_pkg::ENTRY_W-1:0]      ram_rd_data;

   logic [AW_W-1:0]                    acc_rd;
   logic                               clip_rd;
   logic signed [AW_W-1:0]             prod;
   logic [AW_W:0]                      sum;
   logic                               sum_hit;
   logic [AW_W-1:0]                    sum_val;
   logic [smacc_pkg::WOC_W:0]          shifted;
   logic                               ge;
   logic                               q_over;
   logic                               empty;
   logic [VW-1:0]                      mean;
   logic                               mean_sat;

   // Range check and flat address of the incoming element.
   always_comb begin
      in_range_in = (32'(req_segment_index) < 32'(SEGMENTS))
                    && (32'(req_element_index) < 32'(DIM));
      addr_in     = in_range_in
                    ? AW'(32'(req_segment_index) * 32'(DIM) + 32'(req_element_index))
                    : '0;
   end

   // Configuration register and clearing address counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_default_ff <= '0;
         clr_addr_ff      <= '0;
      end else begin
         if (cfg_write) begin
            empty_default_ff <= cfg_data;
         end
         if (cmd.clr_write) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   assign empty_default   = empty_default_ff;
   assign status.clr_last = (32'(clr_addr_ff) == 32'(DEPTH - 1));
   assign status.opcode   = opcode_ff;

   // Entry as read; an element out of range reads as zero with no clip.
   assign acc_rd  = in_range_ff ? ram_rd_data[AW_W-1:0] : '0;
   assign clip_rd = in_range_ff ? ram_rd_data[AW_W] : 1'b0;

   // Weighted addend: signed sample times unsigned weight, which fits in 48 bits.
   assign prod = sample_ff * $signed({1'b0, woc_ff});

   // Saturating sum into the 48-bit accumulator.
   always_comb begin
      sum     = {acc_rd[AW_W-1], acc_rd} + {addend_ff[AW_W-1], addend_ff};
      sum_hit = (sum[AW_W] != sum[AW_W-1]);
      if (!sum_hit) begin
         sum_val = sum[AW_W-1:0];
      end else if (sum[AW_W]) begin
         sum_val = {1'b1, {(AW_W-1){1'b0}}};
      end else begin
         sum_val = {1'b0, {(AW_W-1){1'b1}}};
      end
   end

   // One restoring divide step on the magnitude.
   always_comb begin
      shifted = {rem_ff, quo_ff[AW_W-1]};
      ge      = (shifted >= {1'b0, woc_ff});
   end

   // Signed, clipped quotient or the default for an empty count.
   always_comb begin
      empty  = (woc_ff == '0);
      q_over = neg_ff ? (quo_ff > smacc_pkg::Q_NEG_LIMIT)
                      : (quo_ff > smacc_pkg::Q_POS_LIMIT);
      if (empty) begin
         mean = empty_default_ff;
      end else if (q_over) begin
         mean = neg_ff ? smacc_pkg::Q_MIN : smacc_pkg::Q_MAX;
      end else if (neg_ff) begin
         mean = -quo_ff[VW-1:0];
      end else begin
         mean = quo_ff[VW-1:0];
      end
      mean_sat = clip_ff || (!empty && q_over);
   end

   // Item capture, addend, divider and result payload.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         opcode_ff   <= smacc_pkg::opcode_type'(req_opcode);
         seg_ff      <= req_segment_index;
         elem_ff     <= req_element_index;
         sample_ff   <= req_sample_value;
         woc_ff      <= req_weight_or_count;
         addr_ff     <= addr_in;
         in_range_ff <= in_range_in;
      end
      if (cmd.calc) begin
         addend_ff <= (opcode_ff == smacc_pkg::OP_WADD) ? prod
                                                        : AW_W'(sample_ff);
      end
      if (cmd.div_load) begin
         neg_ff  <= acc_rd[AW_W-1];
         quo_ff  <= acc_rd[AW_W-1] ? -acc_rd : acc_rd;
         rem_ff  <= '0;
         clip_ff <= clip_rd;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? smacc_pkg::WOC_W'(shifted - {1'b0, woc_ff})
                      : shifted[smacc_pkg::WOC_W-1:0];
         quo_ff <= {quo_ff[AW_W-2:0], ge};
      end
      if (cmd.fin) begin
         rsp_mean_value  <= mean;
         rsp_out_segment <= seg_ff;
         rsp_out_element <= elem_ff;
         rsp_was_empty   <= empty;
         rsp_saturated   <= mean_sat;
      end
   end

   // Memory write: clearing pass, accumulate, or finalize writeback.
   always_comb begin
      ram_wr_en   = cmd.clr_write || ((cmd.acc_write || cmd.fin) && in_range_ff);
      ram_wr_addr = cmd.clr_write ? clr_addr_ff : addr_ff;
      if (cmd.clr_write) begin
         ram_wr_data = '0;
      end else if (cmd.acc_write) begin
         ram_wr_data = {clip_rd || sum_hit, sum_val};
      end else begin
         ram_wr_data = {1'b0, AW_W'($signed(mean))};
      end
   end

   smacc_ram #(
      .WIDTH (smacc_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

endmodule

// File: sv/segment_mean_accumulator.sv
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  opcode, segment, element, sample, weight/count
// rsp_      out        rsp_valid/rsp_stall  mean, segment, element, empty flag, clip flag
// csr       in/out     psel/penable/pready  empty_default at paddr 0
//
// An add goes through accept, memory read, addend (multiply), write back.
// A finalize goes through accept, read, load, 48 steps of the one-bit
// restoring divider, then the result goes into the output register.
// After reset the block clears the store, one entry a cycle, all SEGMENTS*DIM
// entries (4096 by default), with req_stall high.
// A finalize waits in its last state while the output register is still full
// and stalled; the next item is accepted as soon as the finalize has left.
module segment_mean_accumulator #(
   parameter int SEGMENTS = smacc_pkg::DEF_SEGMENTS,
   parameter int DIM      = smacc_pkg::DEF_DIM
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [smacc_pkg::OP_W-1:0]            req_opcode,
   input  logic [smacc_pkg::IDX_W-1:0]           req_segment_index,
   input  logic [smacc_pkg::IDX_W-1:0]           req_element_index,
   input  logic signed [smacc_pkg::VAL_W-1:0]    req_sample_value,
   input  logic [smacc_pkg::WOC_W-1:0]           req_weight_or_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [smacc_pkg::VAL_W-1:0]    rsp_mean_value,
   output logic [smacc_pkg::IDX_W-1:0]           rsp_out_segment,
   output logic [smacc_pkg::IDX_W-1:0]           rsp_out_element,
   output logic                                  rsp_was_empty,
   output logic                                  rsp_saturated,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [smacc_pkg::CSR_AW-1:0]          paddr,
   input  logic [smacc_pkg::VAL_W-1:0]           pwdata,
   output logic [smacc_pkg::VAL_W-1:0]           prdata,
   output logic                                  pready
);

   smacc_pkg::cmd_type             cmd;
   smacc_pkg::status_type          status;
   logic                           csr_hit;
   logic                           cfg_write;
   logic [smacc_pkg::VAL_W-1:0]    empty_default;

   // Register decode: one register at index zero.
   assign csr_hit   = (paddr[smacc_pkg::CSR_AW-1] == smacc_pkg::CSR_IDX_EMPTY_DEFAULT);
   assign cfg_write = psel && penable && pwrite && csr_hit;
   assign prdata    = csr_hit ? empty_default : '0;
   assign pready    = 1'b1;

   smacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smacc_dpath #(
      .SEGMENTS (SEGMENTS),
      .DIM      (DIM)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_opcode),
      .req_segment_index   (req_segment_index),
      .req_element_index   (req_element_index),
      .req_sample_value    (req_sample_value),
      .req_weight_or_count (req_weight_or_count),
      .cfg_write           (cfg_write),
      .cfg_data            (pwdata),
      .empty_default       (empty_default),
      .rsp_mean_value      (rsp_mean_value),
      .rsp_out_segment     (rsp_out_segment),
      .rsp_out_element     (rsp_out_element),
      .rsp_was_empty       (rsp_was_empty),
      .rsp_saturated       (rsp_saturated)
   );

endmodule
